// ===== hw/rtl/afc_pkg.sv =====
// Shared types and constants for the box frustum culling core.
// Used by aabb_frustum_cull_core and tb; no dependencies.
`default_nettype none
package afc_pkg;
   localparam int NUM_PLANES  = 6;
   localparam int NUM_CORNERS = 8;
   localparam int FIELD_W     = 32;
   localparam int REQ_DATA_W  = 328;
   localparam int RSP_DATA_W  = 8;

   localparam logic [1:0] REQ_LOAD_PLANE  = 2'd0;
   localparam logic [1:0] REQ_LOAD_CORNER = 2'd1;
   localparam logic [1:0] REQ_TEST_BOX    = 2'd2;

   localparam logic [1:0] REASON_VISIBLE = 2'd0;
   localparam logic [1:0] REASON_PLANE   = 2'd1;
   localparam logic [1:0] REASON_CORNERS = 2'd2;

   // Bit offsets of the 32-bit fields in the request tdata, after the slot.
   localparam int OFS_COEF = 3;
   localparam int OFS_BMIN = 3 + 4 * FIELD_W;
   localparam int OFS_BMAX = 3 + 7 * FIELD_W;
endpackage
`default_nettype wire

// ===== hw/rtl/aabb_frustum_cull_core.sv =====
// Axis-aligned box culling against six planes and eight frustum corners.
// A box test transaction passes through stages 1 to 4 and then the result register.
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds while the result register is full and not taken.
// Reset clears valid bits only; plane and corner stores are undefined until loaded.
// Depends on afc_pkg.
`default_nettype none
module aabb_frustum_cull_core
   import afc_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // slot, coef_x, coef_y, coef_z, coef_w, box_min_x/y/z, box_max_x/y/z, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // visible, cull_reason, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);
   localparam int CW = COORD_WIDTH;
   localparam int PW = 2 * CW;
   localparam int SW = CW + 32 + 3;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [PW-1:0] prod_type;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic      req_acc;
   logic [2:0] slot;
   coord_type in_coef [4];
   coord_type in_bmin [3];
   coord_type in_bmax [3];
   assign req_acc = req_tvalid && adv;
   assign slot    = req_tdata[2:0];
   always_comb begin
      for (int k = 0; k < 4; k++)
         in_coef[k] = req_tdata[OFS_COEF + k*FIELD_W +: CW];
      for (int k = 0; k < 3; k++) begin
         in_bmin[k] = req_tdata[OFS_BMIN + k*FIELD_W +: CW];
         in_bmax[k] = req_tdata[OFS_BMAX + k*FIELD_W +: CW];
      end
   end

   // Stores: written when the load transaction is accepted; plane loads to slots 6 and 7 are ignored.
   coord_type plane_ff  [NUM_PLANES][4];
   coord_type corner_ff [NUM_CORNERS][3];
   always_ff @(posedge clock) begin
      if (req_acc && req_tuser == REQ_LOAD_PLANE && slot < 3'(NUM_PLANES)) begin
         for (int k = 0; k < 4; k++) plane_ff[slot][k] <= in_coef[k];
      end
      if (req_acc && req_tuser == REQ_LOAD_CORNER) begin
         for (int k = 0; k < 3; k++) corner_ff[slot][k] <= in_coef[k];
      end
   end

   // Stage 1: registered box.
   logic      s1_v_ff, s1_v_in;
   coord_type s1_bmin_ff [3];
   coord_type s1_bmax_ff [3];
   assign s1_v_in = req_tvalid && req_tuser == REQ_TEST_BOX;

   // Stage 2: products, plane offsets and corner flags.
   logic      s2_v_ff;
   prod_type  s2_pmin_ff [NUM_PLANES][3];
   prod_type  s2_pmax_ff [NUM_PLANES][3];
   coord_type s2_d_ff    [NUM_PLANES];
   logic      s2_beyond_ff, s2_beyond_in;

   always_comb begin
      logic above, below;
      s2_beyond_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         above = 1'b1;
         below = 1'b1;
         for (int c = 0; c < NUM_CORNERS; c++) begin
            if (!(corner_ff[c][k] > s1_bmax_ff[k])) above = 1'b0;
            if (!(corner_ff[c][k] < s1_bmin_ff[k])) below = 1'b0;
         end
         if (above || below) s2_beyond_in = 1'b1;
      end
   end

   // Stage 3: best (largest) term per axis; the plane maximum over all box
   // corners is the offset plus the sum of these per-axis maxima.
   logic      s3_v_ff;
   prod_type  s3_m_ff [NUM_PLANES][3];
   coord_type s3_d_ff [NUM_PLANES];
   logic      s3_beyond_ff;

   // Stage 4: one outside flag per plane.
   logic                  s4_v_ff;
   logic [NUM_PLANES-1:0] s4_out_ff, s4_out_in;
   logic                  s4_beyond_ff;

   always_comb begin
      logic signed [SW-1:0] sum;
      for (int p = 0; p < NUM_PLANES; p++) begin
         sum = SW'(s3_m_ff[p][0]) + SW'(s3_m_ff[p][1]) + SW'(s3_m_ff[p][2])
             + (SW'(s3_d_ff[p]) <<< 32);
         s4_out_in[p] = sum[SW-1];
      end
   end

   logic       rsp_vis_ff, rsp_vis_in;
   logic [1:0] rsp_reason_ff, rsp_reason_in;
   always_comb begin
      if (|s4_out_ff) begin
         rsp_vis_in    = 1'b0;
         rsp_reason_in = REASON_PLANE;
      end else if (s4_beyond_ff) begin
         rsp_vis_in    = 1'b0;
         rsp_reason_in = REASON_CORNERS;
      end else begin
         rsp_vis_in    = 1'b1;
         rsp_reason_in = REASON_VISIBLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
         s4_v_ff    <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else if (adv) begin
         s1_v_ff    <= s1_v_in;
         s2_v_ff    <= s1_v_ff;
         s3_v_ff    <= s2_v_ff;
         s4_v_ff    <= s3_v_ff;
         rsp_tvalid <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_bmin_ff   <= in_bmin;
         s1_bmax_ff   <= in_bmax;
         for (int p = 0; p < NUM_PLANES; p++) begin
            for (int k = 0; k < 3; k++) begin
               s2_pmin_ff[p][k] <= plane_ff[p][k] * s1_bmin_ff[k];
               s2_pmax_ff[p][k] <= plane_ff[p][k] * s1_bmax_ff[k];
               s3_m_ff[p][k]    <= (s2_pmax_ff[p][k] > s2_pmin_ff[p][k]) ?
                                   s2_pmax_ff[p][k] : s2_pmin_ff[p][k];
            end
            s2_d_ff[p] <= plane_ff[p][3];
            s3_d_ff[p] <= s2_d_ff[p];
         end
         s2_beyond_ff  <= s2_beyond_in;
         s3_beyond_ff  <= s2_beyond_ff;
         s4_beyond_ff  <= s3_beyond_ff;
         s4_out_ff     <= s4_out_in;
         rsp_vis_ff    <= rsp_vis_in;
         rsp_reason_ff <= rsp_reason_in;
      end
   end

   assign rsp_tdata = {5'b0, rsp_reason_ff, rsp_vis_ff};

   a_vis_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_vis_ff == (rsp_reason_ff == REASON_VISIBLE)))
      else $error("visible flag disagrees with cull reason");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (s4_v_ff && adv) |=> rsp_tvalid)
      else $error("test result lost between last stage and output");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(s4_v_ff) && $stable(s1_v_ff)))
      else $error("pipeline moved during a stall");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == REQ_TEST_BOX) |=> s1_v_ff)
      else $error("accepted test transaction did not enter the pipeline");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for aabb_frustum_cull_core: plane and corner loads,
// box tests under random idling, checked against an in-bench culling predictor.
// Depends on afc_pkg and aabb_frustum_cull_core.
module tb;
   import afc_pkg::*;

   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        slot;
      logic [31:0]       coef_x, coef_y, coef_z, coef_w;
      logic [31:0]       bmin_x, bmin_y, bmin_z, bmax_x, bmax_y, bmax_z;
   } box_req_t;

   typedef struct packed {
      logic       visible;
      logic [1:0] reason;
   } cull_rsp_t;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   aabb_frustum_cull_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   box_req_t  pending_reqs[$];
   cull_rsp_t expected_culls[$];
   logic signed [31:0] plane_coef[NUM_PLANES*4];
   logic signed [31:0] corner_pos[NUM_CORNERS*3];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;
   int quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [REQ_DATA_W-1:0] pack_req(box_req_t r);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[2:0] = r.slot;
      d[OFS_COEF +: 128] = {r.coef_w, r.coef_z, r.coef_y, r.coef_x};
      d[OFS_BMIN +: 96]  = {r.bmin_z, r.bmin_y, r.bmin_x};
      d[OFS_BMAX +: 96]  = {r.bmax_z, r.bmax_y, r.bmax_x};
      return d;
   endfunction

   // Exact plane value a*x + b*y + c*z + d at Q32.32 scale.
   function automatic bit plane_below(int p, logic signed [31:0] x,
                                      logic signed [31:0] y, logic signed [31:0] z);
      logic signed [127:0] acc;
      acc = 128'(plane_coef[4*p]) * 128'(x) + 128'(plane_coef[4*p+1]) * 128'(y)
          + 128'(plane_coef[4*p+2]) * 128'(z) + (128'(plane_coef[4*p+3]) <<< 32);
      return acc < 0;
   endfunction

   // Updates the stores for loads; returns 1 with the expected outcome for box tests.
   function automatic bit predict_cull(box_req_t r, output cull_rsp_t res);
      logic signed [31:0] lo[3], hi[3];
      bit all_neg;
      int above, below;
      res = '0;
      if (r.kind == REQ_LOAD_PLANE) begin
         if (r.slot < NUM_PLANES) begin
            plane_coef[4*r.slot]   = r.coef_x;
            plane_coef[4*r.slot+1] = r.coef_y;
            plane_coef[4*r.slot+2] = r.coef_z;
            plane_coef[4*r.slot+3] = r.coef_w;
         end
         return 0;
      end
      if (r.kind == REQ_LOAD_CORNER) begin
         corner_pos[3*r.slot]   = r.coef_x;
         corner_pos[3*r.slot+1] = r.coef_y;
         corner_pos[3*r.slot+2] = r.coef_z;
         return 0;
      end
      if (r.kind != REQ_TEST_BOX) return 0;
      lo = '{r.bmin_x, r.bmin_y, r.bmin_z};
      hi = '{r.bmax_x, r.bmax_y, r.bmax_z};
      for (int p = 0; p < NUM_PLANES; p++) begin
         all_neg = 1;
         for (int c = 0; c < 8; c++)
            if (!plane_below(p, c[0] ? hi[0] : lo[0], c[1] ? hi[1] : lo[1],
                             c[2] ? hi[2] : lo[2]))
               all_neg = 0;
         if (all_neg) begin
            res = '{1'b0, REASON_PLANE};
            return 1;
         end
      end
      for (int k = 0; k < 3; k++) begin
         above = 0;
         below = 0;
         for (int c = 0; c < NUM_CORNERS; c++) begin
            if (corner_pos[3*c+k] > hi[k]) above++;
            if (corner_pos[3*c+k] < lo[k]) below++;
         end
         if (above == NUM_CORNERS || below == NUM_CORNERS) begin
            res = '{1'b0, REASON_CORNERS};
            return 1;
         end
      end
      res = '{1'b1, REASON_VISIBLE};
      return 1;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom;
         default: return 32'(signed'($urandom_range(0, 40 << 16)) - (20 << 16));
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'h8000_0000;
         default: return 32'(signed'($urandom_range(0, 2 << 16)) - (1 << 16));
      endcase
   endfunction

   function automatic box_req_t make_load(logic [1:0] kind, int slot);
      box_req_t r;
      r = '0;
      r.kind = kind;
      r.slot = 3'(slot);
      r.coef_x = rand_coef();
      r.coef_y = rand_coef();
      r.coef_z = rand_coef();
      r.coef_w = $urandom;
      r.bmin_x = $urandom;
      r.bmax_z = $urandom;
      if (kind == REQ_LOAD_CORNER) begin
         r.coef_x = rand_coord();
         r.coef_y = rand_coord();
         r.coef_z = rand_coord();
      end
      return r;
   endfunction

   function automatic box_req_t make_box();
      box_req_t r;
      logic signed [31:0] a, b;
      r = '0;
      r.kind = REQ_TEST_BOX;
      r.slot = 3'($urandom);
      r.coef_x = $urandom;
      r.coef_w = $urandom;
      a = rand_coord(); b = rand_coord();
      {r.bmin_x, r.bmax_x} = ($urandom_range(0, 9) == 0 || a > b) ? {b, a} : {a, b};
      a = rand_coord(); b = rand_coord();
      {r.bmin_y, r.bmax_y} = (a > b) ? {b, a} : {a, b};
      a = rand_coord(); b = rand_coord();
      {r.bmin_z, r.bmax_z} = (a > b) ? {b, a} : {a, b};
      return r;
   endfunction

   task automatic load_frustum();
      for (int p = 0; p < NUM_PLANES; p++)
         pending_reqs.push_back(make_load(REQ_LOAD_PLANE, p));
      for (int c = 0; c < NUM_CORNERS; c++)
         pending_reqs.push_back(make_load(REQ_LOAD_CORNER, c));
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_culls.size() != 0 || req_tvalid)
         @(posedge clock);
   endtask

   // Driver: one transaction offered at a time, held until accepted.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tdata <= pack_req(pending_reqs[0]);
               req_tuser <= pending_reqs[0].kind;
               pending_reqs.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end else if (!req_tvalid && pending_reqs.size() != 0
                      && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pack_req(pending_reqs[0]);
            req_tuser  <= pending_reqs[0].kind;
            pending_reqs.pop_front();
         end
      end
   end

   // Predicts on acceptance, checks results, and runs the watchdog.
   always @(posedge clock) begin
      box_req_t  acc_req;
      cull_rsp_t exp_res, got;
      if (!reset) begin
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
         if (req_tvalid && req_tready) begin
            acc_req = '{req_tuser, req_tdata[2:0],
                        req_tdata[OFS_COEF +: 32], req_tdata[OFS_COEF+32 +: 32],
                        req_tdata[OFS_COEF+64 +: 32], req_tdata[OFS_COEF+96 +: 32],
                        req_tdata[OFS_BMIN +: 32], req_tdata[OFS_BMIN+32 +: 32],
                        req_tdata[OFS_BMIN+64 +: 32], req_tdata[OFS_BMAX +: 32],
                        req_tdata[OFS_BMAX+32 +: 32], req_tdata[OFS_BMAX+64 +: 32]};
            if (predict_cull(acc_req, exp_res)) expected_culls.push_back(exp_res);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[0], rsp_tdata[2:1]};
            if (expected_culls.size() == 0) begin
               $error("unexpected result transaction: visible %0d reason %0d",
                      got.visible, got.reason);
               errors++;
            end else begin
               exp_res = expected_culls.pop_front();
               if (got.visible !== exp_res.visible) begin
                  $error("visible: expected %0d actual %0d", exp_res.visible, got.visible);
                  errors++;
               end
               if (got.reason !== exp_res.reason) begin
                  $error("cull_reason: expected %0d actual %0d", exp_res.reason, got.reason);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (pending_reqs.size() == 0 && expected_culls.size() == 0 && !req_tvalid))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      box_req_t r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme frustum, ignored slots and type, degenerate boxes.
      load_frustum();
      r = make_load(REQ_LOAD_PLANE, 6);
      r.coef_x = '1; r.coef_w = '1;
      pending_reqs.push_back(r);
      r.slot = 3'd7;
      pending_reqs.push_back(r);
      r = make_box();
      r.kind = 2'd3;
      pending_reqs.push_back(r);
      r = make_box();
      {r.bmin_x, r.bmin_y, r.bmin_z} = {3{32'h8000_0000}};
      {r.bmax_x, r.bmax_y, r.bmax_z} = {3{32'h7fff_ffff}};
      pending_reqs.push_back(r);
      {r.bmin_x, r.bmax_x} = {32'h7fff_ffff, 32'h8000_0000};
      pending_reqs.push_back(r);
      r.bmin_x = '0; r.bmax_x = '0; r.bmin_y = '0; r.bmax_y = '0;
      r.bmin_z = '0; r.bmax_z = '0;
      pending_reqs.push_back(r);
      // Plane 0 is x >= 0: a box at negative x is culled; one touching x == 0 is not.
      r = make_load(REQ_LOAD_PLANE, 0);
      {r.coef_x, r.coef_y, r.coef_z, r.coef_w} = {32'h0001_0000, 96'h0};
      pending_reqs.push_back(r);
      r = make_box();
      r.bmin_x = -(5 << 16); r.bmax_x = -1;
      pending_reqs.push_back(r);
      r.bmax_x = 0;
      pending_reqs.push_back(r);
      // All corners at one point; a box ending exactly there does not cull them.
      for (int c = 0; c < NUM_CORNERS; c++) begin
         r = make_load(REQ_LOAD_CORNER, c);
         {r.coef_x, r.coef_y, r.coef_z} = {32'h0003_0000, 32'h0, 32'h0};
         pending_reqs.push_back(r);
      end
      r = make_box();
      {r.bmin_x, r.bmax_x} = {32'h0001_0000, 32'h0003_0000};
      pending_reqs.push_back(r);
      r.bmax_x = 32'h0002_ffff;
      pending_reqs.push_back(r);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            3: begin send_idle_pct = 18; recv_stall_pct = 18; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         load_frustum();
         if (phase == 4) hold_off = 200;
         for (int i = 0; i < 60; i++) begin
            case ($urandom_range(0, 9))
               0: pending_reqs.push_back(make_load(REQ_LOAD_PLANE, $urandom_range(0, 7)));
               1: pending_reqs.push_back(make_load(REQ_LOAD_CORNER, $urandom_range(0, 7)));
               default: pending_reqs.push_back(make_box());
            endcase
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (errors == 0 && expected_culls.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/afc_pkg.sv
hw/rtl/aabb_frustum_cull_core.sv
verif/tb.sv
